@@ sv/pcb_pkg.sv @@
// -----------------------------------------------------------------------------
// pcb_pkg
// Shared types and constants for the particle cell binning block.
// -----------------------------------------------------------------------------
package pcb_pkg;

	localparam int CELLS_X        = 8;
	localparam int CELLS_Y        = 8;
	localparam int CELLS_Z        = 8;
	localparam int SLOTS_PER_CELL = 16;
	localparam int GRID_CELLS     = CELLS_X * CELLS_Y * CELLS_Z;
	localparam int NUM_SLOTS      = GRID_CELLS * SLOTS_PER_CELL;
	localparam int CELL_W         = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam int SLOT_W         = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
	localparam int ADDR_W         = CELL_W + SLOT_W;
	localparam int COUNT_W        = $clog2(SLOTS_PER_CELL + 1);
	localparam int AXIS_W         = 7;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_PLACED = 3'd0,
		ST_FULL   = 3'd1,
		ST_OOB    = 3'd2,
		ST_RVALID = 3'd3,
		ST_REMPTY = 3'd4,
		ST_CLEAR  = 3'd5
	} status_t;

	localparam logic [1:0] REG_CELL_SIZE = 2'd0;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] particle_number;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [8:0]  read_cell;
		logic [3:0]  read_slot;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  cell_number;
		logic [3:0]  slot_number;
		logic [15:0] out_particle;
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
	} out_word_t;

	// divider control and result
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic              done;
		logic              in_range;
		logic [AXIS_W-1:0] idx;
	} div_res_t;

endpackage

@@ sv/pcb_stream_if.sv @@
// -----------------------------------------------------------------------------
// pcb_stream_if
// Valid/ready channel carrying one word of a given type.
// -----------------------------------------------------------------------------
interface pcb_stream_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/pcb_ram.sv @@
// -----------------------------------------------------------------------------
// pcb_ram
// Generic single-port synchronous RAM, registered read.
// -----------------------------------------------------------------------------
module pcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ sv/pcb_axis_div.sv @@
// -----------------------------------------------------------------------------
// pcb_axis_div
// Restoring divider: |pos| / (cell_size << 16), two quotient bits per cycle,
// with grid bound check for one axis.
// -----------------------------------------------------------------------------
module pcb_axis_div
	import pcb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctl_t          ctl,
	input  logic [31:0]       pos,
	input  logic [14:0]       cell_size,
	input  logic [6:0]        limit,
	output div_res_t          res
);
	// |pos| <= 2^31; quotient fits 16 bits since divisor >= 2^16
	logic [31:0] mag_q;
	logic [15:0] quo_q;
	logic [16:0] rem_q;
	logic        neg_q;
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic        done_q;

	logic [17:0] r1, r2;
	logic [16:0] a1, a2;
	logic        b1, b2;

	always_comb begin
		r1 = {rem_q, mag_q[31]};
		b1 = r1 >= {3'b0, cell_size};
		a1 = b1 ? 17'(r1 - {3'b0, cell_size}) : r1[16:0];
		r2 = {a1, mag_q[30]};
		b2 = r2 >= {3'b0, cell_size};
		a2 = b2 ? 17'(r2 - {3'b0, cell_size}) : r2[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// integer part only: low 16 bits of magnitude never change the quotient
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			neg_q <= pos[31];
			mag_q <= pos[31] ? 32'(-pos) : pos;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && cnt_q < 5'd8) begin
			rem_q <= a2;
			mag_q <= {mag_q[29:0], 2'b00};
			quo_q <= {quo_q[13:0], b1, b2};
		end
	end

	always_comb begin
		res.done     = done_q;
		res.idx      = quo_q[6:0];
		res.in_range = (cell_size != 15'd0) && !(neg_q && quo_q != 16'd0)
			&& (quo_q < {9'd0, limit});
	end
endmodule

@@ sv/particle_cell_binning_core.sv @@
// -----------------------------------------------------------------------------
// particle_cell_binning_core
// Bins particles into a 3D cell grid; counts and slot store live in RAMs.
// -----------------------------------------------------------------------------
// channel   dir  word          notes
// in_ch     in   in_word_t     one command per word
// out_ch    out  out_word_t    one result per command (cmd 3 gives none)
// apb       in   cell_size     register 0 at byte address 0
//
// Insert: after the word is taken the three parallel 2-bit/cycle dividers
// run, then count read, check/store write, store read and output. Out of
// bounds: the result follows the dividers. Read: count read, check, store
// read and output. Clear: one count entry zeroed per cycle. After reset a
// clearing pass over every count entry runs before the first word.
// A result waits in the output register; the next word may be processed
// meanwhile and stalls only in S_OUT until the waiting result has left.
// -----------------------------------------------------------------------------
module particle_cell_binning_core
	import pcb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	pcb_stream_if.sink   in_ch,
	pcb_stream_if.source out_ch,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	typedef enum logic [7:0] {
		S_INIT  = 8'b00000001,
		S_IDLE  = 8'b00000010,
		S_DIV   = 8'b00000100,
		S_CRD   = 8'b00001000,
		S_CCHK  = 8'b00010000,
		S_SRD   = 8'b00100000,
		S_SOUT  = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t      state_q;
	logic [14:0] cell_size_q;
	in_word_t    w_q;
	out_word_t   o_q;
	out_word_t   res_q;
	logic        ovalid_q;
	logic [CELL_W-1:0] sweep_q;
	logic [CELL_W-1:0] cell_q;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_CELL_SIZE) ? {17'd0, cell_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= 15'd1;
		end else if (psel && penable && pwrite && paddr == REG_CELL_SIZE) begin
			cell_size_q <= pwdata[14:0];
		end
	end

	// dividers, one per axis
	div_ctl_t dctl;
	div_res_t rx, ry, rz;
	assign dctl.start = in_ch.valid && in_ch.ready && in_ch.data.cmd == CMD_INSERT;

	pcb_axis_div u_dx (.clk, .arst_n, .ctl(dctl), .pos(in_ch.data.pos_x),
		.cell_size(cell_size_q), .limit(7'(CELLS_X)), .res(rx));
	pcb_axis_div u_dy (.clk, .arst_n, .ctl(dctl), .pos(in_ch.data.pos_y),
		.cell_size(cell_size_q), .limit(7'(CELLS_Y)), .res(ry));
	pcb_axis_div u_dz (.clk, .arst_n, .ctl(dctl), .pos(in_ch.data.pos_z),
		.cell_size(cell_size_q), .limit(7'(CELLS_Z)), .res(rz));

	logic in_range;
	logic [CELL_W-1:0] cell_calc;
	assign in_range = rx.in_range && ry.in_range && rz.in_range;
	assign cell_calc = CELL_W'(rx.idx + ry.idx * CELLS_X
		+ rz.idx * (CELLS_X * CELLS_Y));

	// count RAM
	logic              cnt_we;
	logic [CELL_W-1:0] cnt_addr;
	logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
	pcb_ram #(.WIDTH(COUNT_W), .DEPTH(GRID_CELLS)) u_cnt (.clk, .we(cnt_we),
		.addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata));

	// slot store RAMs
	logic              st_we;
	logic [ADDR_W-1:0] st_addr;
	logic [15:0]       rd_id;
	logic [31:0]       rd_x, rd_y, rd_z;
	pcb_ram #(.WIDTH(16), .DEPTH(NUM_SLOTS)) u_sid (.clk, .we(st_we),
		.addr(st_addr), .wdata(w_q.particle_number), .rdata(rd_id));
	pcb_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_sx (.clk, .we(st_we),
		.addr(st_addr), .wdata(w_q.pos_x), .rdata(rd_x));
	pcb_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_sy (.clk, .we(st_we),
		.addr(st_addr), .wdata(w_q.pos_y), .rdata(rd_y));
	pcb_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_sz (.clk, .we(st_we),
		.addr(st_addr), .wdata(w_q.pos_z), .rdata(rd_z));

	logic rd_cell_ok;
	assign rd_cell_ok = 32'(w_q.read_cell) < GRID_CELLS;

	// read address held through S_SRD so the slot data lands in S_SOUT
	always_comb begin
		cnt_we    = 1'b0;
		cnt_addr  = cell_q;
		cnt_wdata = '0;
		st_we     = 1'b0;
		st_addr   = {cell_q, w_q.read_slot};
		unique case (state_q)
			S_INIT: begin
				cnt_we   = 1'b1;
				cnt_addr = sweep_q;
			end
			S_CCHK: begin
				if (w_q.cmd == CMD_INSERT && 32'(cnt_rdata) < SLOTS_PER_CELL) begin
					cnt_we    = 1'b1;
					cnt_wdata = COUNT_W'(cnt_rdata + 1'b1);
					st_we     = 1'b1;
					st_addr   = {cell_q, SLOT_W'(cnt_rdata)};
				end else begin
					st_addr = {cell_q, SLOT_W'(w_q.read_slot)};
				end
			end
			default: ;
		endcase
	end

	// result moves to the output register once the previous one has left
	logic res_load;
	assign res_load = state_q == S_OUT && w_q.cmd != CMD_CLEAR
		&& (!ovalid_q || out_ch.ready);

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.valid && out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= o_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			sweep_q  <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					sweep_q <= CELL_W'(sweep_q + 1'b1);
					if (32'(sweep_q) == GRID_CELLS - 1) begin
						state_q <= (w_q.cmd == CMD_CLEAR) ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						unique case (in_ch.data.cmd)
							CMD_INSERT: state_q <= S_DIV;
							CMD_READ:   state_q <= S_CRD;
							CMD_CLEAR: begin
								state_q <= S_OUT;
								sweep_q <= '0;
							end
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: if (rx.done) state_q <= in_range ? S_CRD : S_OUT;
				S_CRD:  state_q <= S_CCHK;
				S_CCHK: state_q <= S_SRD;
				S_SRD:  state_q <= S_SOUT;
				S_SOUT: state_q <= S_OUT;
				S_OUT: begin
					if (w_q.cmd == CMD_CLEAR) begin
						state_q <= S_INIT;
					end else if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// clear reuses the init sweep; result raised at the end of the sweep
	logic clear_done;
	assign clear_done = state_q == S_INIT && 32'(sweep_q) == GRID_CELLS - 1
		&& w_q.cmd == CMD_CLEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= in_word_t'{cmd: CMD_NONE, default: '0};
		end else if (state_q == S_IDLE && in_ch.valid && in_ch.ready) begin
			w_q <= in_ch.data;
		end else if (clear_done) begin
			w_q.cmd <= CMD_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid && in_ch.ready) begin
			cell_q <= CELL_W'(in_ch.data.read_cell);
		end else if (state_q == S_DIV && rx.done) begin
			cell_q <= cell_calc;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_ch.valid && in_ch.ready && in_ch.data.cmd == CMD_CLEAR) begin
					o_q <= out_word_t'{status: ST_CLEAR, default: '0};
				end
			end
			S_DIV: begin
				o_q <= out_word_t'{status: ST_OOB, default: '0};
			end
			S_CRD: begin
				o_q <= '0;
			end
			S_CCHK: begin
				if (w_q.cmd == CMD_INSERT) begin
					o_q.cell_number <= 9'(cell_q);
					if (32'(cnt_rdata) < SLOTS_PER_CELL) begin
						o_q.status      <= ST_PLACED;
						o_q.slot_number <= 4'(cnt_rdata);
					end else begin
						o_q.status <= ST_FULL;
					end
				end else begin
					o_q.cell_number <= w_q.read_cell;
					o_q.slot_number <= w_q.read_slot;
					o_q.status <= (rd_cell_ok && {1'b0, w_q.read_slot} < 5'(cnt_rdata))
						? ST_RVALID : ST_REMPTY;
				end
			end
			S_SOUT: begin
				if (o_q.status == ST_RVALID) begin
					o_q.out_particle <= rd_id;
					o_q.out_x        <= rd_x;
					o_q.out_y        <= rd_y;
					o_q.out_z        <= rd_z;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == S_IDLE)
		else $error("word taken while busy");
	a_store_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> w_q.cmd == CMD_INSERT)
		else $error("store written outside insert");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");
`endif
endmodule

@@ sim/tb_particle_cell_binning_core.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_particle_cell_binning_core
// Self-checking bench for the cell binning core: a driver feeds command words
// from a queue, a scoreboard predicts every result and a monitor compares it.
// -----------------------------------------------------------------------------
module tb_particle_cell_binning_core;
	import pcb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pcb_stream_if #(.word_t(in_word_t))  in_ch ();
	pcb_stream_if #(.word_t(out_word_t)) out_ch ();

	particle_cell_binning_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state: the block's registers and RAMs, mirrored
	logic [14:0] bin_edge;
	logic [4:0]  fill_count [GRID_CELLS];
	logic [15:0] held_ident [NUM_SLOTS];
	logic [31:0] held_x     [NUM_SLOTS];
	logic [31:0] held_y     [NUM_SLOTS];
	logic [31:0] held_z     [NUM_SLOTS];

	in_word_t  pending_cmds [$];
	out_word_t expected_results [$];
	int        fail_count;
	bit        sink_hold;      // request for the long receiver hold-off
	bit        hold_armed;
	int        hold_left;
	bit        in_fire;        // input word taken at the last rising edge

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly short, sometimes long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// cell index along one axis; truncation toward zero, bounds as in grid
	function automatic bit axis_bin(input logic [31:0] coord, input int limit,
		output int idx);
		logic [31:0] mag;
		logic [47:0] divisor;
		longint unsigned q;
		mag = coord[31] ? (~coord + 32'd1) : coord;
		divisor = {bin_edge, 16'd0};
		idx = 0;
		if (divisor == 0) return 1'b0;
		q = longint'(mag) / longint'(divisor);
		if (coord[31] && q != 0) return 1'b0;
		if (q >= limit) return 1'b0;
		idx = int'(q);
		return 1'b1;
	endfunction

	// compute the result of one accepted word and update the mirror
	function automatic void bin_predict(input in_word_t w);
		out_word_t r;
		int cx, cy, cz, c, a;
		bit ok;
		r = '0;
		case (cmd_t'(w.cmd))
			CMD_INSERT: begin
				ok = axis_bin(w.pos_x, CELLS_X, cx);
				ok = axis_bin(w.pos_y, CELLS_Y, cy) && ok;
				ok = axis_bin(w.pos_z, CELLS_Z, cz) && ok;
				if (!ok) begin
					r.status = ST_OOB;
				end else begin
					c = cx + cy * CELLS_X + cz * CELLS_X * CELLS_Y;
					r.cell_number = c[8:0];
					if (fill_count[c] < SLOTS_PER_CELL) begin
						a = c * SLOTS_PER_CELL + fill_count[c];
						held_ident[a] = w.particle_number;
						held_x[a] = w.pos_x;
						held_y[a] = w.pos_y;
						held_z[a] = w.pos_z;
						r.status = ST_PLACED;
						r.slot_number = fill_count[c][3:0];
						fill_count[c] = fill_count[c] + 5'd1;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			CMD_READ: begin
				r.cell_number = w.read_cell;
				r.slot_number = w.read_slot;
				c = w.read_cell;
				if (c < GRID_CELLS && w.read_slot < fill_count[c]) begin
					a = c * SLOTS_PER_CELL + w.read_slot;
					r.status = ST_RVALID;
					r.out_particle = held_ident[a];
					r.out_x = held_x[a];
					r.out_y = held_y[a];
					r.out_z = held_z[a];
				end else begin
					r.status = ST_REMPTY;
				end
			end
			CMD_CLEAR: begin
				foreach (fill_count[i]) fill_count[i] = '0;
				r.status = ST_CLEAR;
			end
			default: return;   // command 3 gives no word
		endcase
		expected_results.push_back(r);
	endfunction

	// driver: offers queued words, predicting each one after acceptance
	int src_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			src_gap = 0;
		end else begin
			if (in_fire) begin
				bin_predict(in_ch.data);
				void'(pending_cmds.pop_front());
				src_gap = pick_gap();
			end
			if (src_gap > 0) begin
				src_gap--;
				in_ch.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_cmds[0];
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver ready: random stalls, plus one long hold-off on request
	int sink_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			sink_gap = 0;
			hold_left = 0;
		end else begin
			if (sink_hold && !hold_armed) begin
				hold_left = 800;
				hold_armed = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				sink_gap = pick_gap();
			end
		end
	end

	// monitor: compare at the accepting edge against the oldest expectation
	always @(posedge clk) begin
		out_word_t e, g;
		in_fire = arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			g = out_ch.data;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected word status=%0d", $time, g.status);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				if (e.status !== g.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, g.status);
					fail_count++;
				end
				if (e.cell_number !== g.cell_number) begin
					$display("%0t: cell exp %0d got %0d", $time, e.cell_number,
						g.cell_number);
					fail_count++;
				end
				if (e.slot_number !== g.slot_number) begin
					$display("%0t: slot exp %0d got %0d", $time, e.slot_number,
						g.slot_number);
					fail_count++;
				end
				if (e.out_particle !== g.out_particle) begin
					$display("%0t: particle exp %h got %h", $time, e.out_particle,
						g.out_particle);
					fail_count++;
				end
				if (e.out_x !== g.out_x || e.out_y !== g.out_y || e.out_z !== g.out_z) begin
					$display("%0t: pos exp %h %h %h got %h %h %h", $time, e.out_x,
						e.out_y, e.out_z, g.out_x, g.out_y, g.out_z);
					fail_count++;
				end
			end
		end
	end

	// wait until queue drained, all results in, then the clear latency
	task automatic drain();
		while (pending_cmds.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	// APB write of cell_size while idle
	task automatic set_bin_edge(input logic [14:0] v);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= REG_CELL_SIZE; pwdata <= {17'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		bin_edge = v;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	function automatic in_word_t mk_insert(input logic [31:0] x, y, z);
		in_word_t w;
		w = '0;
		w.cmd = CMD_INSERT;
		w.particle_number = 16'($urandom());
		w.pos_x = x; w.pos_y = y; w.pos_z = z;
		w.read_cell = 9'($urandom()); w.read_slot = 4'($urandom());
		return w;
	endfunction

	function automatic in_word_t mk_read(input int c, input int s);
		in_word_t w;
		w = mk_insert($urandom(), $urandom(), $urandom());
		w.cmd = CMD_READ;
		w.read_cell = 9'(c); w.read_slot = 4'(s);
		return w;
	endfunction

	// coordinate inside the grid for the current edge, sometimes outside
	function automatic logic [31:0] rand_coord();
		longint span;
		span = longint'(bin_edge) * 65536 * CELLS_X;
		if ($urandom_range(0, 9) == 0) return $urandom();
		if ($urandom_range(0, 9) == 0)
			return -$urandom_range(0, bin_edge * 65536 - 1);
		if (span > 64'h7fff_ffff) span = 64'h7fff_ffff;
		return 32'($urandom_range(0, 32'(span - 1)));
	endfunction

	// random phase: mostly inserts and reads of random slots, some clears and no-op words
	task automatic random_phase(input int n);
		in_word_t w;
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0: begin
					w = mk_insert(0, 0, 0);
					w.cmd = CMD_CLEAR;
				end
				1: begin
					w = mk_insert($urandom(), $urandom(), $urandom());
					w.cmd = CMD_NONE;
					k--;
				end
				2, 3, 4, 5, 6, 7, 8:
					w = mk_read($urandom_range(0, 511), $urandom_range(0, 15));
				default:
					w = mk_insert(rand_coord(), rand_coord(), rand_coord());
			endcase
			pending_cmds.push_back(w);
		end
		drain();
	endtask

	initial begin
		in_word_t w;
		int k;
		fail_count = 0;
		sink_hold = 1'b0;
		bin_edge = 15'd1;
		foreach (fill_count[i]) fill_count[i] = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset edge 1, extremes and special cases
		pending_cmds.push_back(mk_insert(0, 0, 0));
		pending_cmds.push_back(mk_insert(32'h0007_ffff, 32'h0007_ffff, 32'h0007_ffff));
		pending_cmds.push_back(mk_insert(32'h0008_0000, 0, 0));
		pending_cmds.push_back(mk_insert(32'hffff_0001, 32'hffff_ffff, 0));
		pending_cmds.push_back(mk_insert(32'hffff_0000, 0, 0));
		pending_cmds.push_back(mk_insert(32'h8000_0000, 32'h7fff_ffff, 0));
		w = mk_insert(32'h0001_0000, 0, 0);
		w.particle_number = 16'hffff;
		pending_cmds.push_back(w);
		pending_cmds.push_back(mk_read(0, 0));
		pending_cmds.push_back(mk_read(0, 1));
		pending_cmds.push_back(mk_read(1, 0));
		pending_cmds.push_back(mk_read(511, 0));
		pending_cmds.push_back(mk_read(511, 15));
		for (k = 0; k < 17; k++)
			pending_cmds.push_back(mk_insert(32'h0002_8000, 32'h0003_0000, 0));
		pending_cmds.push_back(mk_read(2 + 3 * CELLS_X, 15));
		w = mk_read(0, 0); w.cmd = CMD_NONE;
		pending_cmds.push_back(w);
		w = mk_read(0, 0); w.cmd = CMD_CLEAR;
		pending_cmds.push_back(w);
		pending_cmds.push_back(mk_read(2 + 3 * CELLS_X, 0));
		drain();

		// long receiver hold-off while words keep coming
		sink_hold = 1'b1;
		for (k = 0; k < 20; k++)
			pending_cmds.push_back(mk_insert(rand_coord(), rand_coord(), rand_coord()));
		drain();

		random_phase(150);
		set_bin_edge(15'd0);           // every insert out of bounds
		random_phase(40);
		set_bin_edge(15'd32767);       // widest cells, every in-range axis index 0 or 1
		random_phase(60);
		set_bin_edge(15'd3);
		random_phase(150);
		set_bin_edge(15'($urandom_range(1, 32767)));
		random_phase(60);
		set_bin_edge(15'd1);
		random_phase(150);

		if (fail_count == 0)
			$display("particle_cell_binning_core regression: pass");
		else
			$display("particle_cell_binning_core regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("particle_cell_binning_core regression: fail");
		$finish;
	end

endmodule
